@@ rtl/indexed_list_engine_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the indexed list engine
// Concurrent assertion wrappers that compile away when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_ENGINE_MACROS_SVH
`define INDEXED_LIST_ENGINE_MACROS_SVH

`ifndef ASSERT_OFF
// A property that must hold at every clock edge outside reset.
`define ILE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// A condition in one cycle that implies another in the following cycle.
`define ILE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ILE_ASSERT(lbl, clk, rst_n, prop, msg)
`define ILE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ rtl/ile_pkg.sv @@
// ----------------------------------------------------------------------------
// Indexed list engine package
// Operation codes, field widths and the request and response payload types.
// ----------------------------------------------------------------------------
package ile_pkg;

	localparam int MODE_W = 3;
	localparam int POS_W  = 7;
	localparam int VAL_W  = 32;
	localparam int LEN_W  = 7;

	localparam logic [MODE_W-1:0] MODE_READ   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_HEAD   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_TAIL   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_AT     = 3'd3;
	localparam logic [MODE_W-1:0] MODE_DELETE = 3'd4;

	typedef struct packed {
		logic [MODE_W-1:0]       mode;
		logic [POS_W-1:0]        position;
		logic signed [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] read_value;
		logic                    found;
		logic                    accepted;
		logic                    full_reject;
		logic [LEN_W-1:0]        list_length;
	} rsp_t;

endpackage

@@ rtl/ile_if.sv @@
// ----------------------------------------------------------------------------
// Indexed list engine channels
// Valid/ready channels that carry list operations in and results out.
// ----------------------------------------------------------------------------
interface ile_req_if;
	logic          valid;
	logic          ready;
	ile_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ile_rsp_if;
	logic          valid;
	logic          ready;
	ile_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/indexed_list_engine.sv @@
// ----------------------------------------------------------------------------
// Indexed list engine
// Ordered list of signed words kept compacted in a memory, head at index 0.
// ----------------------------------------------------------------------------
// A read passes through S_READ and then S_DONE. An insert or a delete alternates
// S_MOVE_RD and S_MOVE_WR once per shifted entry, then reaches S_DONE. Rejected
// or ignored requests go straight to S_DONE. One request is in flight at a
// time; each shifted entry is read from the store and then written back one
// slot over. Reset empties the list; the memory itself is not cleared.
// ----------------------------------------------------------------------------
`include "indexed_list_engine_macros.svh"

module indexed_list_engine #(
	parameter int CAPACITY = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	ile_req_if.sink    req,
	ile_rsp_if.source  rsp
);

	// Address width for the store, width for the element count (which must
	// reach CAPACITY itself), and a common width for comparing the count with
	// the seven-bit request position.
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > ile_pkg::POS_W) ? CW : ile_pkg::POS_W;

	// Sequencer states.
	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_READ    = 3'd1;
	localparam logic [2:0] S_MOVE_RD = 3'd2;
	localparam logic [2:0] S_MOVE_WR = 3'd3;
	localparam logic [2:0] S_DONE    = 3'd4;

	logic [2:0]                        state_q;
	logic [CW-1:0]                     count_q;
	logic [CW-1:0]                     idx_q;
	logic [CW-1:0]                     bound_q;
	logic                              dir_down_q;
	logic signed [ile_pkg::VAL_W-1:0]  val_q;
	logic                              hit_q;
	logic                              acc_q;
	logic                              full_q;
	logic                              rsp_vld_q;
	ile_pkg::rsp_t                     rsp_q;

	logic [XW-1:0]                     pos_x;
	logic [XW-1:0]                     cnt_x;
	logic                              is_full;
	logic [CW-1:0]                     src_idx;
	logic                              more;
	logic                              out_free;

	logic                              mem_we;
	logic [AW-1:0]                     mem_waddr;
	logic signed [ile_pkg::VAL_W-1:0]  mem_wdata;
	logic                              mem_re;
	logic [AW-1:0]                     mem_raddr;
	logic signed [ile_pkg::VAL_W-1:0]  mem_rdata;

	assign pos_x   = XW'(req.data.position);
	assign cnt_x   = XW'(count_q);
	assign is_full = (count_q == CW'(CAPACITY));

	// The result register is free when it is empty or being drained this cycle.
	assign out_free = !rsp_vld_q || rsp.ready;

	// A new request is taken only while no operation is under way.
	assign req.ready = (state_q == S_IDLE);

	// The stepper supplies both the copy source and the loop-continue test.
	ile_step #(
		.CW(CW)
	) u_step (
		.dir_down (dir_down_q),
		.idx      (idx_q),
		.bound    (bound_q),
		.src_idx  (src_idx),
		.more     (more)
	);

	// Memory control. During a shift the source entry is read in one cycle and
	// written one slot over in the next. When the loop ends on an insert, the
	// new value drops into the gap that the loop opened.
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = src_idx[AW-1:0];
		mem_we    = 1'b0;
		mem_waddr = idx_q[AW-1:0];
		mem_wdata = val_q;
		case (state_q)
			S_READ: begin
				mem_re    = 1'b1;
				mem_raddr = idx_q[AW-1:0];
			end
			S_MOVE_RD: begin
				mem_re = more;
				mem_we = !more && !dir_down_q;
			end
			S_MOVE_WR: begin
				mem_we    = 1'b1;
				mem_wdata = mem_rdata;
			end
			default: begin
			end
		endcase
	end

	ile_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_en   (mem_re),
		.rd_addr (mem_raddr),
		.rd_data (mem_rdata)
	);

	// Sequencer. On acceptance the request is decoded into a read, a gap
	// opening (insert), a gap closing (delete) or a direct result. The store
	// is kept compacted, so an insert shifts the entries from the tail down to
	// the insertion place up by one, and a delete shifts the entries above the
	// removed one down by one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_DONE;
						case (req.data.mode)
							ile_pkg::MODE_READ: begin
								if (pos_x < cnt_x) begin
									state_q <= S_READ;
								end
							end
							ile_pkg::MODE_HEAD, ile_pkg::MODE_TAIL: begin
								if (!is_full) begin
									state_q <= S_MOVE_RD;
								end
							end
							ile_pkg::MODE_AT: begin
								if (pos_x <= cnt_x && !is_full) begin
									state_q <= S_MOVE_RD;
								end
							end
							ile_pkg::MODE_DELETE: begin
								if (pos_x < cnt_x) begin
									state_q <= S_MOVE_RD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_READ: begin
					state_q <= S_DONE;
				end
				S_MOVE_RD: begin
					if (more) begin
						state_q <= S_MOVE_WR;
					end else begin
						state_q <= S_DONE;
						count_q <= dir_down_q ? (count_q - CW'(1)) : (count_q + CW'(1));
					end
				end
				S_MOVE_WR: begin
					state_q <= S_MOVE_RD;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Operation status flags; loaded on acceptance, accepted set when a shift loop ends.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			acc_q  <= 1'b0;
			full_q <= 1'b0;
		end else begin
			if (state_q == S_IDLE && req.valid) begin
				hit_q  <= 1'b0;
				acc_q  <= 1'b0;
				full_q <= 1'b0;
				case (req.data.mode)
					ile_pkg::MODE_READ: begin
						hit_q <= (pos_x < cnt_x);
					end
					ile_pkg::MODE_HEAD, ile_pkg::MODE_TAIL: begin
						full_q <= is_full;
					end
					ile_pkg::MODE_AT: begin
						full_q <= (pos_x <= cnt_x) && is_full;
					end
					default: begin
					end
				endcase
			end else if (state_q == S_MOVE_RD && !more) begin
				acc_q <= 1'b1;
			end
		end
	end

	// Loop index and bound. An insert starts at the tail and walks down to the
	// place; a delete starts at the removed index and walks up toward the count.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			val_q      <= req.data.value;
			idx_q      <= pos_x[CW-1:0];
			bound_q    <= count_q;
			dir_down_q <= 1'b0;
			case (req.data.mode)
				ile_pkg::MODE_HEAD: begin
					idx_q   <= count_q;
					bound_q <= '0;
				end
				ile_pkg::MODE_TAIL: begin
					idx_q   <= count_q;
					bound_q <= count_q;
				end
				ile_pkg::MODE_AT: begin
					idx_q   <= count_q;
					bound_q <= pos_x[CW-1:0];
				end
				ile_pkg::MODE_DELETE: begin
					dir_down_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end else if (state_q == S_MOVE_WR) begin
			idx_q <= src_idx;
		end
	end

	// Result register. It decouples the sequencer from the response channel:
	// the finished result is held here until the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			rsp_q.read_value  <= hit_q ? mem_rdata : '1;
			rsp_q.found       <= hit_q;
			rsp_q.accepted    <= acc_q;
			rsp_q.full_reject <= full_q;
			rsp_q.list_length <= cnt_x[ile_pkg::LEN_W-1:0];
		end
	end

	assign rsp.valid = rsp_vld_q;
	assign rsp.data  = rsp_q;

	// The element count never exceeds the capacity.
	`ILE_ASSERT(a_count_bound, clk, arst_n, count_q <= CW'(CAPACITY), "count above capacity")
	// The count changes only when a shift loop finishes.
	`ILE_ASSERT_NEXT(a_count_stable, clk, arst_n, state_q != S_MOVE_RD, $stable(count_q), "count changed outside loop end")
	// Every store write lands inside the capacity.
	`ILE_ASSERT(a_write_range, clk, arst_n, !mem_we || (idx_q < CW'(CAPACITY)), "write beyond capacity")
	// A change and a refusal never come together in one result.
	`ILE_ASSERT(a_flags_excl, clk, arst_n, !(rsp_vld_q && rsp_q.accepted && rsp_q.full_reject), "accepted and full_reject both set")

endmodule

@@ rtl/ile_mem.sv @@
// ----------------------------------------------------------------------------
// Indexed list engine element store
// Single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module ile_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic                             clk,
	input  logic                             wr_en,
	input  logic [AW-1:0]                    wr_addr,
	input  logic signed [ile_pkg::VAL_W-1:0] wr_data,
	input  logic                             rd_en,
	input  logic [AW-1:0]                    rd_addr,
	output logic signed [ile_pkg::VAL_W-1:0] rd_data
);

	logic signed [ile_pkg::VAL_W-1:0] mem_q [DEPTH];
	logic signed [ile_pkg::VAL_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/ile_step.sv @@
// ----------------------------------------------------------------------------
// Indexed list engine index stepper
// Shared increment/decrement and compare unit that walks the shift loop.
// ----------------------------------------------------------------------------
module ile_step #(
	parameter int CW = 7
) (
	input  logic          dir_down,
	input  logic [CW-1:0] idx,
	input  logic [CW-1:0] bound,
	output logic [CW-1:0] src_idx,
	output logic          more
);

	// Opening a gap walks downward from the tail and copies each entry up;
	// closing a gap walks upward and copies each entry down.
	assign src_idx = dir_down ? (idx + CW'(1)) : (idx - CW'(1));
	assign more    = dir_down ? (src_idx < bound) : (idx > bound);

endmodule
